// ===== rtl/b64e_pkg.sv =====
// Package for the Base64 stream encoder: queue entry type, sizes and
// the sextet-to-character mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_ZERO = 2'd0;
	localparam phase_t PH_ONE  = 2'd1;
	localparam phase_t PH_TWO  = 2'd2;

	// one classified byte: up to four characters, index of the last one used,
	// and whether that last one ends the message
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} entry_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		case (v) inside
			[6'd0 : 6'd25]:  c = 8'd65 + w;
			[6'd26 : 6'd51]: c = 8'd97 + (w - 8'd26);
			[6'd52 : 6'd61]: c = 8'd48 + (w - 8'd52);
			6'd62:           c = 8'h2B;
			default:         c = 8'h2F;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: front end, entry queue, serializer.
// Depends on b64e_pkg, b64e_front, b64e_fifo, b64e_back.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 encoder, standard alphabet with '=' padding. Push one
// byte per transaction, with final_byte set on the last byte of a message;
// characters come out one per pop transaction, last_char marking the end of
// the message. The input takes one byte per cycle while the four-entry queue
// has room; the serializer delivers one character per cycle while pop is held
// and the queue is not empty, so sustained throughput is set by the output:
// 4 characters per 3 bytes in a run, up to 4 for a final byte. An accepted
// byte is queued first, then its first character is loaded into out_char.
module base64_stream_encoder import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            last_char
);

	entry_t new_entry;
	entry_t head;
	logic   accept;
	logic   q_empty;
	logic   q_pop;

	assign accept = push && !full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.entry      (new_entry)
	);

	b64e_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (new_entry),
		.rd_en   (q_pop),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks group phase and leftover bits, and
// builds one queue entry per byte. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output entry_t          entry
);

	phase_t     phase_q;
	logic [3:0] left_q;
	phase_t     phase_d;
	logic [3:0] left_d;

	always_comb begin
		entry.chars    = {4{PAD_CHAR}};
		entry.last_idx = 2'd0;
		entry.fin      = final_byte;
		phase_d        = phase_q;
		left_d         = left_q;
		case (phase_q)
			PH_ONE: begin
				entry.chars[0] = b64_char({left_q[1:0], data_byte[7:4]});
				entry.chars[1] = b64_char({data_byte[3:0], 2'b00});
				entry.last_idx = final_byte ? 2'd2 : 2'd0;
				left_d         = data_byte[3:0];
				phase_d        = PH_TWO;
			end
			PH_TWO: begin
				entry.chars[0] = b64_char({left_q, data_byte[7:6]});
				entry.chars[1] = b64_char(data_byte[5:0]);
				entry.last_idx = 2'd1;
				left_d         = 4'd0;
				phase_d        = PH_ZERO;
			end
			default: begin
				entry.chars[0] = b64_char(data_byte[7:2]);
				entry.chars[1] = b64_char({data_byte[1:0], 4'b0000});
				entry.last_idx = final_byte ? 2'd3 : 2'd0;
				left_d         = {2'b00, data_byte[1:0]};
				phase_d        = PH_ONE;
			end
		endcase
		if (final_byte) begin
			phase_d = PH_ZERO;
			left_d  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ZERO;
			left_q  <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
// Short entry queue between front end and serializer.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_fifo import b64e_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_data,
	input  wire logic   rd_en,
	output entry_t      rd_data,
	output logic        full,
	output logic        empty
);

	entry_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// Back end: walks the head queue entry into an output register, one
// character per cycle while the output is popped. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire entry_t     head,
	input  wire logic       q_empty,
	output logic            q_pop,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      out_char,
	output logic            last_char
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       at_end;

	assign empty  = !valid_q;
	assign load   = !q_empty && (!valid_q || pop);
	assign at_end = (idx_q == head.last_idx);
	assign q_pop  = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char  <= head.chars[idx_q];
			last_char <= at_end && head.fin;
		end
	end

endmodule

`default_nettype wire
